/* rtl/assert_macros.svh */
// assertion macros for the textured wall column shader
// expects clk and rst_n (synchronous, active low) in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TWS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TWS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tws_pkg.sv */
// constants and codes shared by the textured wall column shader
// no dependencies
`default_nettype none

package tws_pkg;

  // texture geometry
  localparam int TEX_SIZE  = 32;
  localparam int TEX_BITS  = $clog2(TEX_SIZE);
  localparam int TEX_CELLS = TEX_SIZE * TEX_SIZE;
  localparam int TEX_AW    = 2 * TEX_BITS;

  // field widths
  localparam int REQ_W   = 1;
  localparam int IDX_W   = 10;
  localparam int COLOR_W = 24;
  localparam int DIST_W  = 16;
  localparam int FRAC_W  = 8;
  localparam int ROW_W   = 10;
  localparam int CH_W    = 8;
  localparam int CFG_W   = 11;

  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 1'b0;
  localparam logic [REQ_W-1:0] REQ_SHADE = 1'b1;

  // column height: 0.75 in q.8, scaled by another 256 for a q.8 quotient
  localparam int HEIGHT_SCALE   = 49152;
  localparam int HEIGHT_SCALE_W = 16;
  localparam int NUM_W          = CFG_W + HEIGHT_SCALE_W;

  // span and texture row arithmetic
  localparam int COUNT_SHIFT = 8;
  localparam int SPAN_SHIFT  = 9;
  localparam int P9_SHIFT    = 9;
  localparam int P9_W        = NUM_W + 1;
  localparam int N2_W        = P9_W + TEX_BITS;
  localparam int DV_W        = NUM_W + 1;
  localparam int Q2_W        = TEX_BITS + 1;

  // linear fog, divide by 14 as halve then multiply by a reciprocal of 7
  localparam int FOG_NEAR   = 256;
  localparam int FOG_FAR    = 3840;
  localparam int FOG_W      = 9;
  localparam int FOG_DIFF_W = 12;
  localparam int FOG_RECIP  = 2341;
  localparam int FOG_RCP_W  = 12;
  localparam int FOG_SHIFT  = 14;
  localparam int FOG_PROD_W = FOG_DIFF_W - 1 + FOG_RCP_W;

endpackage

`default_nettype wire

/* rtl/tws_if.sv */
// valid/ready channel interfaces for the shader input and result beats
// depends on tws_pkg
`default_nettype none

interface tws_in_if;
  logic                         valid;
  logic                         ready;
  logic [tws_pkg::REQ_W-1:0]    req_type;
  logic [tws_pkg::IDX_W-1:0]    texel_index;
  logic [tws_pkg::COLOR_W-1:0]  texel_color;
  logic [tws_pkg::DIST_W-1:0]   wall_distance;
  logic [tws_pkg::FRAC_W-1:0]   hit_fraction;
  logic                         side_wall;
  logic [tws_pkg::ROW_W-1:0]    screen_row;

  modport source (
    output valid, req_type, texel_index, texel_color, wall_distance,
           hit_fraction, side_wall, screen_row,
    input  ready
  );

  modport sink (
    input  valid, req_type, texel_index, texel_color, wall_distance,
           hit_fraction, side_wall, screen_row,
    output ready
  );
endinterface

interface tws_out_if;
  logic                       valid;
  logic                       ready;
  logic [tws_pkg::ROW_W-1:0]  pixel_row;
  logic                       is_wall;
  logic [tws_pkg::CH_W-1:0]   red;
  logic [tws_pkg::CH_W-1:0]   green;
  logic [tws_pkg::CH_W-1:0]   blue;

  modport source (
    output valid, pixel_row, is_wall, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, pixel_row, is_wall, red, green, blue,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/textured_wall_column_shader.sv */
// textured wall column shader: one pixel of a raycast wall column per clock, or one
// texel load per clock into the 32x32 rgb texture, while the skid is empty; uses
// tws_pkg, tws_if and assert_macros.svh. a beat with req_type REQ_WRITE stores
// texel_color at texel_index (addresses past the texture are dropped) and gives no
// result; a REQ_SHADE beat gives exactly one result beat, in order. the pipe takes a
// new beat before earlier ones finish; a shade beat passes the input register, the
// 27-step restoring divider for the column height, the span stages, the 6-step
// divider for the texture row and the texture memory stage. an output register
// plus a one-beat skid part the result side from the pipe, so input keeps flowing
// while a finished beat waits; in_ch.ready drops only once the skid is full.
// texture writes travel the pipe and land at the texture memory stage, so every
// shade beat sees exactly the writes that came before it. the texture has no reset
// or clearing pass: a never-written texel shades to undefined colour. the user must
// write screen_height via cfg_we/cfg_wdata only while the block is idle; not enforced.
`default_nettype none
`include "assert_macros.svh"

module textured_wall_column_shader (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tws_pkg::CFG_W-1:0]   cfg_wdata,
  tws_in_if.sink                      in_ch,
  tws_out_if.source                   out_ch
);

  // beat state carried down the pipe
  typedef struct packed {
    logic                          wr;
    logic [tws_pkg::IDX_W-1:0]     tex_idx;
    logic [tws_pkg::COLOR_W-1:0]   color;
    logic [tws_pkg::FOG_W-1:0]     fog;
    logic [tws_pkg::TEX_BITS-1:0]  u;
    logic                          side;
    logic [tws_pkg::ROW_W-1:0]     row;
  } item_t;

  typedef struct packed {
    logic [tws_pkg::ROW_W-1:0]  row;
    logic                       is_wall;
    logic [tws_pkg::CH_W-1:0]   red;
    logic [tws_pkg::CH_W-1:0]   green;
    logic [tws_pkg::CH_W-1:0]   blue;
  } result_t;

  // ---------------------------------------------------------------------------
  // configuration and global advance
  // ---------------------------------------------------------------------------
  logic [tws_pkg::CFG_W-1:0]  height_r;
  logic [tws_pkg::NUM_W-1:0]  num;        // 0.75 * height in q.16
  logic                       pipe_en;    // whole pipe moves when the skid is free
  logic                       skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= tws_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      height_r <= cfg_wdata;
    end
  end

  assign num         = tws_pkg::NUM_W'(height_r) * tws_pkg::NUM_W'(tws_pkg::HEIGHT_SCALE);
  assign pipe_en     = !skid_valid_r;
  assign in_ch.ready = pipe_en;

  // ---------------------------------------------------------------------------
  // stage a: input register
  // ---------------------------------------------------------------------------
  logic                          a_v_r;
  logic [tws_pkg::REQ_W-1:0]     a_req_r;
  logic [tws_pkg::IDX_W-1:0]     a_idx_r;
  logic [tws_pkg::COLOR_W-1:0]   a_color_r;
  logic [tws_pkg::DIST_W-1:0]    a_dist_r;
  logic [tws_pkg::FRAC_W-1:0]    a_frac_r;
  logic                          a_side_r;
  logic [tws_pkg::ROW_W-1:0]     a_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (pipe_en) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_req_r   <= in_ch.req_type;
      a_idx_r   <= in_ch.texel_index;
      a_color_r <= in_ch.texel_color;
      a_dist_r  <= in_ch.wall_distance;
      a_frac_r  <= in_ch.hit_fraction;
      a_side_r  <= in_ch.side_wall;
      a_row_r   <= in_ch.screen_row;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: fog factor, texture column, zero distance fix
  // ---------------------------------------------------------------------------
  logic [tws_pkg::DIST_W-1:0]      b_dist_nxt;
  logic [tws_pkg::FOG_DIFF_W-1:0]  fog_diff;
  logic [tws_pkg::FOG_PROD_W-1:0]  fog_prod;
  item_t                           b_it_nxt;

  always_comb begin
    b_dist_nxt = (a_dist_r == '0) ? tws_pkg::DIST_W'(1) : a_dist_r;

    // (far - d) / 14 as ((far - d) >> 1) * ceil(2^14 / 7) >> 14, exact over the ramp
    fog_diff = tws_pkg::FOG_DIFF_W'(tws_pkg::FOG_FAR)
             - a_dist_r[tws_pkg::FOG_DIFF_W-1:0];
    fog_prod = tws_pkg::FOG_PROD_W'(fog_diff[tws_pkg::FOG_DIFF_W-1:1])
             * tws_pkg::FOG_PROD_W'(tws_pkg::FOG_RECIP);

    b_it_nxt.wr      = (a_req_r == tws_pkg::REQ_WRITE);
    b_it_nxt.tex_idx = a_idx_r;
    b_it_nxt.color   = a_color_r;
    b_it_nxt.side    = a_side_r;
    b_it_nxt.row     = a_row_r;
    b_it_nxt.u       = tws_pkg::TEX_BITS'(a_frac_r >> (tws_pkg::FRAC_W - tws_pkg::TEX_BITS));
    if (a_dist_r <= tws_pkg::DIST_W'(tws_pkg::FOG_NEAR)) begin
      b_it_nxt.fog = tws_pkg::FOG_W'(tws_pkg::FOG_NEAR);
    end else if (a_dist_r >= tws_pkg::DIST_W'(tws_pkg::FOG_FAR)) begin
      b_it_nxt.fog = '0;
    end else begin
      b_it_nxt.fog = fog_prod[tws_pkg::FOG_SHIFT +: tws_pkg::FOG_W];
    end
  end

  // ---------------------------------------------------------------------------
  // height divider: l8 = num / d, one restoring step per stage, msb first
  // ---------------------------------------------------------------------------
  logic                          d1_v_r   [0:tws_pkg::NUM_W];
  item_t                         d1_it_r  [0:tws_pkg::NUM_W];
  logic [tws_pkg::DIST_W-1:0]    d1_den_r [0:tws_pkg::NUM_W-1];
  logic [tws_pkg::DIST_W-1:0]    d1_rem_r [1:tws_pkg::NUM_W-1];
  logic [tws_pkg::NUM_W-1:0]     d1_q_r   [1:tws_pkg::NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r[0] <= 1'b0;
    end else if (pipe_en) begin
      d1_v_r[0] <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d1_it_r[0]  <= b_it_nxt;
      d1_den_r[0] <= b_dist_nxt;
    end
  end

  for (genvar s = 0; s < tws_pkg::NUM_W; s++) begin : g_div1
    logic [tws_pkg::DIST_W-1:0]  rem_in;
    logic [tws_pkg::NUM_W-1:0]   q_in;
    logic [tws_pkg::DIST_W:0]    trial;
    logic                        fit;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = d1_rem_r[s];
      assign q_in   = d1_q_r[s];
    end

    assign trial = {rem_in, num[tws_pkg::NUM_W-1-s]};
    assign fit   = (trial >= {1'b0, d1_den_r[s]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v_r[s+1] <= 1'b0;
      end else if (pipe_en) begin
        d1_v_r[s+1] <= d1_v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        d1_it_r[s+1] <= d1_it_r[s];
        d1_q_r[s+1]  <= {q_in[tws_pkg::NUM_W-2:0], fit};
      end
    end

    if (s < tws_pkg::NUM_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          d1_den_r[s+1] <= d1_den_r[s];
          d1_rem_r[s+1] <= fit ? tws_pkg::DIST_W'(trial - {1'b0, d1_den_r[s]})
                               : tws_pkg::DIST_W'(trial);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage s1: span start, row count and centring offset
  // ---------------------------------------------------------------------------
  logic [tws_pkg::NUM_W-1:0]   l8;
  logic [tws_pkg::NUM_W-1:0]   h8;
  logic                        l8_short;   // column shorter than the screen

  logic                        s1_v_r;
  item_t                       s1_it_r;
  logic [tws_pkg::ROW_W-1:0]   s1_start_r;
  logic [tws_pkg::CFG_W-1:0]   s1_count_r;
  logic [tws_pkg::NUM_W-1:0]   s1_off_r;
  logic [tws_pkg::NUM_W-1:0]   s1_l8_r;
  logic                        s1_lnz_r;

  assign l8       = d1_q_r[tws_pkg::NUM_W];
  assign h8       = tws_pkg::NUM_W'(height_r) << tws_pkg::COUNT_SHIFT;
  assign l8_short = (l8 < h8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r <= d1_v_r[tws_pkg::NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_it_r  <= d1_it_r[tws_pkg::NUM_W];
      s1_l8_r  <= l8;
      s1_lnz_r <= (l8 != '0);
      if (l8_short) begin
        s1_start_r <= tws_pkg::ROW_W'((h8 - l8) >> tws_pkg::SPAN_SHIFT);
        s1_count_r <= tws_pkg::CFG_W'(l8 >> tws_pkg::COUNT_SHIFT);
        s1_off_r   <= '0;
      end else begin
        s1_start_r <= '0;
        s1_count_r <= height_r;
        s1_off_r   <= l8 - h8;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage s2: span test and texture position in q.9
  // ---------------------------------------------------------------------------
  logic [tws_pkg::ROW_W-1:0]  span_i;
  logic                       span_hit;

  logic                       s2_v_r;
  item_t                      s2_it_r;
  logic                       s2_in_r;
  logic [tws_pkg::P9_W-1:0]   s2_p9_r;
  logic [tws_pkg::NUM_W-1:0]  s2_l8_r;

  assign span_i   = s1_it_r.row - s1_start_r;
  assign span_hit = s1_lnz_r && (s1_it_r.row >= s1_start_r)
                 && (tws_pkg::CFG_W'(span_i) < s1_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (pipe_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_it_r <= s1_it_r;
      s2_in_r <= span_hit;
      s2_p9_r <= (tws_pkg::P9_W'(span_i) << tws_pkg::P9_SHIFT) + tws_pkg::P9_W'(s1_off_r);
      s2_l8_r <= s1_l8_r;
    end
  end

  // ---------------------------------------------------------------------------
  // texture row divider: v = p9 * (size - 1) / (2 * l8), clamped to size - 1
  // top quotient bit flags an overflow, then one bit per stage
  // ---------------------------------------------------------------------------
  logic                          d2_v_r   [0:tws_pkg::Q2_W];
  item_t                         d2_it_r  [0:tws_pkg::Q2_W];
  logic                          d2_in_r  [0:tws_pkg::Q2_W];
  logic [tws_pkg::N2_W-1:0]      d2_rem_r [0:tws_pkg::Q2_W-1];
  logic [tws_pkg::DV_W-1:0]      d2_dv_r  [0:tws_pkg::Q2_W-1];
  logic [tws_pkg::Q2_W-1:0]      d2_q_r   [1:tws_pkg::Q2_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v_r[0] <= 1'b0;
    end else if (pipe_en) begin
      d2_v_r[0] <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d2_it_r[0]  <= s2_it_r;
      d2_in_r[0]  <= s2_in_r;
      d2_rem_r[0] <= (tws_pkg::N2_W'(s2_p9_r) << tws_pkg::TEX_BITS) - tws_pkg::N2_W'(s2_p9_r);
      d2_dv_r[0]  <= {s2_l8_r, 1'b0};
    end
  end

  for (genvar t = 0; t < tws_pkg::Q2_W; t++) begin : g_div2
    localparam int SH = tws_pkg::TEX_BITS - t;

    logic [tws_pkg::Q2_W-1:0]  q_in;
    logic [tws_pkg::N2_W-1:0]  trial;
    logic                      fit;

    if (t == 0) begin : g_first
      assign q_in = '0;
    end else begin : g_next
      assign q_in = d2_q_r[t];
    end

    assign trial = tws_pkg::N2_W'(d2_dv_r[t]) << SH;
    assign fit   = (d2_rem_r[t] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_v_r[t+1] <= 1'b0;
      end else if (pipe_en) begin
        d2_v_r[t+1] <= d2_v_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        d2_it_r[t+1] <= d2_it_r[t];
        d2_in_r[t+1] <= d2_in_r[t];
        d2_q_r[t+1]  <= {q_in[tws_pkg::Q2_W-2:0], fit};
      end
    end

    if (t < tws_pkg::Q2_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          d2_dv_r[t+1]  <= d2_dv_r[t];
          d2_rem_r[t+1] <= fit ? d2_rem_r[t] - trial : d2_rem_r[t];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // texture memory stage: writes land here, in beat order with the reads
  // ---------------------------------------------------------------------------
  logic [tws_pkg::COLOR_W-1:0]   tex_mem [tws_pkg::TEX_CELLS];
  logic [tws_pkg::Q2_W-1:0]      v_raw;
  logic [tws_pkg::TEX_BITS-1:0]  v_row;
  logic [tws_pkg::TEX_AW-1:0]    rd_addr;
  logic [tws_pkg::TEX_AW-1:0]    wr_addr;
  logic                          wr_ok;
  item_t                         mem_it;
  logic                          mem_v;

  logic                          m_v_r;
  item_t                         m_it_r;
  logic                          m_in_r;
  logic [tws_pkg::COLOR_W-1:0]   rdata_r;

  assign mem_it  = d2_it_r[tws_pkg::Q2_W];
  assign mem_v   = d2_v_r[tws_pkg::Q2_W];
  assign v_raw   = d2_q_r[tws_pkg::Q2_W];
  assign v_row   = v_raw[tws_pkg::TEX_BITS] ? '1 : v_raw[tws_pkg::TEX_BITS-1:0];
  assign rd_addr = {v_row, mem_it.u};
  assign wr_addr = tws_pkg::TEX_AW'(mem_it.tex_idx);
  assign wr_ok   = (32'(mem_it.tex_idx) < tws_pkg::TEX_CELLS);

  always_ff @(posedge clk) begin
    if (pipe_en && mem_v && mem_it.wr && wr_ok) begin
      tex_mem[wr_addr] <= mem_it.color;
    end
    if (pipe_en && mem_v && !mem_it.wr) begin
      rdata_r <= tex_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (pipe_en) begin
      m_v_r <= mem_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m_it_r <= mem_it;
      m_in_r <= d2_in_r[tws_pkg::Q2_W];
    end
  end

  // ---------------------------------------------------------------------------
  // shading: side walls quarter the channel, others take the fog factor
  // ---------------------------------------------------------------------------
  function automatic logic [tws_pkg::CH_W-1:0] shade_ch(
    input logic [tws_pkg::CH_W-1:0]   c,
    input logic                       side,
    input logic [tws_pkg::FOG_W-1:0]  fog
  );
    logic [tws_pkg::CH_W+tws_pkg::FOG_W-1:0] prod;
    prod = (tws_pkg::CH_W + tws_pkg::FOG_W)'(c) * (tws_pkg::CH_W + tws_pkg::FOG_W)'(fog);
    if (side) begin
      shade_ch = c >> 2;
    end else begin
      shade_ch = prod[tws_pkg::CH_W +: tws_pkg::CH_W];
    end
  endfunction

  result_t  res_nxt;
  logic     res_valid;

  always_comb begin
    res_nxt.row     = m_it_r.row;
    res_nxt.is_wall = m_in_r;
    res_nxt.red     = '0;
    res_nxt.green   = '0;
    res_nxt.blue    = '0;
    if (m_in_r) begin
      res_nxt.red   = shade_ch(rdata_r[2*tws_pkg::CH_W +: tws_pkg::CH_W], m_it_r.side,
                               m_it_r.fog);
      res_nxt.green = shade_ch(rdata_r[tws_pkg::CH_W +: tws_pkg::CH_W], m_it_r.side,
                               m_it_r.fog);
      res_nxt.blue  = shade_ch(rdata_r[0 +: tws_pkg::CH_W], m_it_r.side, m_it_r.fog);
    end
  end

  // texel loads end here, only shade beats give a result
  assign res_valid = m_v_r && !m_it_r.wr;

  // ---------------------------------------------------------------------------
  // output register and skid
  // ---------------------------------------------------------------------------
  logic     out_valid_r;
  result_t  out_data_r;
  result_t  skid_data_r;
  logic     out_take;
  logic     res_push;

  assign out_take = out_valid_r && out_ch.ready;
  assign res_push = pipe_en && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // pipe is frozen, drain the skid into the output register
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= res_push;
    end else if (res_push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || out_take) begin
      if (res_push) begin
        out_data_r <= res_nxt;
      end
    end else if (res_push) begin
      skid_data_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_row = out_data_r.row;
  assign out_ch.is_wall   = out_data_r.is_wall;
  assign out_ch.red       = out_data_r.red;
  assign out_ch.green     = out_data_r.green;
  assign out_ch.blue      = out_data_r.blue;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `TWS_ASSERT_IMPL(a_skid_needs_out, skid_valid_r, out_valid_r, "skid beat without output beat")
  `TWS_ASSERT_IMPL(a_skid_fill, $rose(skid_valid_r), $past(out_valid_r) && !$past(out_ch.ready), "skid filled while output moved")
  `TWS_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(m_it_r) && $stable(rdata_r) && $stable(m_v_r), "memory stage moved during stall")
  `TWS_ASSERT_IMPL(a_blank_off_wall, out_valid_r && !out_data_r.is_wall, out_data_r.red == '0 && out_data_r.green == '0 && out_data_r.blue == '0, "colour outside wall span")

endmodule

`default_nettype wire
